// ===== rtl/tcbp_pkg.sv =====
// Shared types, constants and register codes for the two-class buffer pool.
// Used by every module under rtl/; depends on nothing.

package tcbp_pkg;

   localparam int SMALL_BUFFERS = 512;
   localparam int JUMBO_BUFFERS = 8;
   localparam int NUM_CLASSES   = 2;

   localparam int IDX_W      = 9;
   localparam int PAYLOAD_W  = 16;
   localparam int HEADROOM_W = 11;
   localparam int SIZE_W     = 16;
   localparam int NEED_W     = 17;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 3;

   localparam logic [HEADROOM_W-1:0] HEADROOM_RESET   = 11'd128;
   localparam logic [SIZE_W-1:0]     SMALL_SIZE_RESET = 16'd1536;
   localparam logic [SIZE_W-1:0]     JUMBO_SIZE_RESET = 16'd65535;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic {
      CLASS_SMALL = 1'b0,
      CLASS_JUMBO = 1'b1
   } class_type;

   typedef enum logic [2:0] {
      ST_SMALL_OK  = 3'd0,
      ST_JUMBO_OK  = 3'd1,
      ST_PROMOTED  = 3'd2,
      ST_TOO_BIG   = 3'd3,
      ST_EXHAUSTED = 3'd4,
      ST_RELEASED  = 3'd5,
      ST_IGNORED   = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADROOM   = 2'd0,
      CSR_SMALL_SIZE = 2'd1,
      CSR_JUMBO_SIZE = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [HEADROOM_W-1:0] headroom_bytes;
      logic [SIZE_W-1:0]     small_buffer_bytes;
      logic [SIZE_W-1:0]     jumbo_buffer_bytes;
   } csr_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [PAYLOAD_W-1:0] min_payload_bytes;
      class_type            release_class;
      logic [IDX_W-1:0]     release_index;
   } req_type;

   typedef struct packed {
      status_type       status;
      class_type        granted_class;
      logic [IDX_W-1:0] granted_index;
   } rsp_type;

   // per-class request to the free lists
   typedef struct packed {
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] push_idx;
   } list_cmd_type;

   // per-class view of the free lists for the staged item
   typedef struct packed {
      logic             empty;
      logic             full;
      logic [IDX_W-1:0] top;
      logic             in_use;
   } list_stat_type;

   function automatic int class_depth(int c);
      return (c == int'(CLASS_SMALL)) ? SMALL_BUFFERS : JUMBO_BUFFERS;
   endfunction

endpackage

// ===== rtl/two_class_buffer_pool.sv =====
// Two-class buffer pool: request register, grant logic, result register.
// A beat is held in the request register, its result in the result register.
// Throughput: one request per cycle unless results stall, set by one pop or push per class.
// Reset (synchronous): registers back to 128/1536/65535, both stacks full with
// index 0 on top, no buffer in use; requests are taken from the next cycle on.
// Depends on tcbp_pkg, tcbp_csr, tcbp_lists and tcbp_alloc.

module two_class_buffer_pool (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] min_payload_bytes, [16] release_class, [25:17] release_index
   input  logic [tcbp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] cmd
   input  logic                                req_tuser,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] granted_class, [9:1] granted_index
   output logic [tcbp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [2:0] status
   output logic [tcbp_pkg::RSP_USER_W-1:0]     rsp_tuser,

   input  logic                                csr_wr_en,
   input  logic [tcbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcbp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tcbp_pkg::*;

   csr_type                         csr;
   req_type                         item_ff, item_in;
   logic                            stage_valid_ff, stage_valid_in;
   rsp_type                         rsp_ff, rsp_calc;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            advance, accept;
   list_cmd_type  [NUM_CLASSES-1:0] list_cmd;
   list_stat_type [NUM_CLASSES-1:0] list_stat;

   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !reset && (!stage_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   assign item_in.cmd               = cmd_type'(req_tuser);
   assign item_in.min_payload_bytes = req_tdata[15:0];
   assign item_in.release_class     = class_type'(req_tdata[16]);
   assign item_in.release_index     = req_tdata[25:17];

   assign stage_valid_in = accept || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_calc;
      end
   end

   tcbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr       (csr)
   );

   // in-use flags are looked up as the request beat is taken
   tcbp_lists u_lists (
      .clock  (clock),
      .reset  (reset),
      .cmd    (list_cmd),
      .rd_en  (accept),
      .rd_idx (item_in.release_index),
      .stat   (list_stat)
   );

   tcbp_alloc u_alloc (
      .go   (advance),
      .item (item_ff),
      .csr  (csr),
      .stat (list_stat),
      .rsp  (rsp_calc),
      .cmd  (list_cmd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.granted_index, rsp_ff.granted_class});
   assign rsp_tuser  = rsp_ff.status;

endmodule

// ===== rtl/tcbp_csr.sv =====
// Configuration registers of the buffer pool: headroom, small and jumbo sizes.
// Depends on tcbp_pkg.

module tcbp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [tcbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcbp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tcbp_pkg::csr_type                csr
);
   import tcbp_pkg::*;

   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADROOM:   csr_in.headroom_bytes     = csr_wdata[HEADROOM_W-1:0];
            CSR_SMALL_SIZE: csr_in.small_buffer_bytes = csr_wdata[SIZE_W-1:0];
            CSR_JUMBO_SIZE: csr_in.jumbo_buffer_bytes = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.headroom_bytes     <= HEADROOM_RESET;
         csr_ff.small_buffer_bytes <= SMALL_SIZE_RESET;
         csr_ff.jumbo_buffer_bytes <= JUMBO_SIZE_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== rtl/tcbp_lists.sv =====
// Free-list stacks and in-use flags for both buffer classes, held in memories.
// Depends on tcbp_pkg; driven by tcbp_alloc through the top level.

module tcbp_lists (
   input  logic                                                clock,
   input  logic                                                reset,
   input  tcbp_pkg::list_cmd_type  [tcbp_pkg::NUM_CLASSES-1:0] cmd,
   input  logic                                                rd_en,
   input  logic [tcbp_pkg::IDX_W-1:0]                          rd_idx,
   output wire tcbp_pkg::list_stat_type [tcbp_pkg::NUM_CLASSES-1:0] stat
);
   import tcbp_pkg::*;

   genvar c;
   for (c = 0; c < NUM_CLASSES; c++) begin : g_class
      localparam int DEPTH = class_depth(c);
      localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
      localparam int CW    = $clog2(DEPTH + 1);

      logic [CW-1:0]    count_ff, count_in;
      logic [CW-1:0]    mark_ff, mark_in;     // lowest fill level seen since reset
      logic [IDX_W-1:0] top_ff, top_in;
      logic [CW-1:0]    rd_pos_full;
      logic [AW-1:0]    rd_pos_ff, rd_pos_in;
      logic             rd_fb_ff, rd_fb_in;
      logic [IDX_W-1:0] stack_rd_ff;
      logic [IDX_W-1:0] rd_val;
      logic [IDX_W-1:0] stack_mem [DEPTH];

      logic             inuse_mem [DEPTH];
      logic             iu_rd_ff;
      logic [AW-1:0]    iu_addr_ff;
      logic             byp_ff, byp_val_ff;
      logic             iu_we, iu_wval;
      logic [AW-1:0]    iu_waddr;
      logic             iu_valid;

      // Stack slots below the low-water mark were never written and still
      // hold their reset contents, i.e. DEPTH-1-slot.
      assign rd_val = rd_fb_ff ? IDX_W'(AW'(DEPTH - 1) - rd_pos_ff) : stack_rd_ff;

      always_comb begin
         count_in = count_ff;
         top_in   = top_ff;
         if (cmd[c].pop) begin
            count_in = count_ff - 1'b1;
            top_in   = rd_val;
         end else if (cmd[c].push) begin
            count_in = count_ff + 1'b1;
            top_in   = cmd[c].push_idx;
         end
         mark_in     = (count_in < mark_ff) ? count_in : mark_ff;
         // prefetch the entry just below the new top
         rd_pos_full = count_in - CW'(2);
         rd_pos_in   = rd_pos_full[AW-1:0];
         rd_fb_in    = rd_pos_full < mark_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff  <= CW'(DEPTH);
            mark_ff   <= CW'(DEPTH);
            top_ff    <= '0;
            rd_pos_ff <= AW'(DEPTH - 2);
            rd_fb_ff  <= 1'b1;
         end else begin
            count_ff  <= count_in;
            mark_ff   <= mark_in;
            top_ff    <= top_in;
            rd_pos_ff <= rd_pos_in;
            rd_fb_ff  <= rd_fb_in;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd[c].push) begin
            stack_mem[count_ff[AW-1:0]] <= cmd[c].push_idx;
         end
         stack_rd_ff <= stack_mem[rd_pos_in];
      end

      // in-use flags: set on grant, cleared on release
      assign iu_we    = cmd[c].pop | cmd[c].push;
      assign iu_wval  = cmd[c].pop;
      assign iu_waddr = cmd[c].pop ? AW'(top_ff) : AW'(cmd[c].push_idx);

      always_ff @(posedge clock) begin
         if (iu_we) begin
            inuse_mem[iu_waddr] <= iu_wval;
         end
         if (rd_en) begin
            iu_rd_ff   <= inuse_mem[AW'(rd_idx)];
            iu_addr_ff <= AW'(rd_idx);
            byp_ff     <= iu_we && (iu_waddr == AW'(rd_idx));
            byp_val_ff <= iu_wval;
         end
      end

      // Only indices below DEPTH-mark have ever been granted; the rest read
      // as free without any clearing of the flag memory.
      assign iu_valid = CW'(iu_addr_ff) < (CW'(DEPTH) - mark_ff);

      assign stat[c] = '{
         empty:  (count_ff == '0),
         full:   (count_ff == CW'(DEPTH)),
         top:    top_ff,
         in_use: (byp_ff ? byp_val_ff : (iu_valid & iu_rd_ff))
      };
   end

endmodule

// ===== rtl/tcbp_alloc.sv =====
// Grant and release decision for one staged request: size check, class choice,
// promotion and release validation. Depends on tcbp_pkg.

module tcbp_alloc (
   input  logic                                                go,
   input  tcbp_pkg::req_type                                   item,
   input  tcbp_pkg::csr_type                                   csr,
   input  tcbp_pkg::list_stat_type [tcbp_pkg::NUM_CLASSES-1:0] stat,
   output tcbp_pkg::rsp_type                                   rsp,
   output tcbp_pkg::list_cmd_type  [tcbp_pkg::NUM_CLASSES-1:0] cmd
);
   import tcbp_pkg::*;

   logic [NEED_W-1:0] need;
   logic              over_jumbo, over_small;
   logic              idx_in_range;
   list_stat_type     rel_stat;

   assign need       = NEED_W'(item.min_payload_bytes) + NEED_W'(csr.headroom_bytes);
   assign over_jumbo = need > NEED_W'(csr.jumbo_buffer_bytes);
   assign over_small = need > NEED_W'(csr.small_buffer_bytes);
   assign rel_stat   = stat[item.release_class];

   always_comb begin
      if (item.release_class == CLASS_SMALL) begin
         idx_in_range = 32'(item.release_index) < 32'(SMALL_BUFFERS);
      end else begin
         idx_in_range = 32'(item.release_index) < 32'(JUMBO_BUFFERS);
      end
   end

   always_comb begin
      rsp.status        = ST_IGNORED;
      rsp.granted_class = CLASS_SMALL;
      rsp.granted_index = '0;
      cmd               = '0;
      if (item.cmd == CMD_ALLOC) begin
         priority if (over_jumbo) begin
            rsp.status = ST_TOO_BIG;
         end else if (over_small) begin
            if (!stat[CLASS_JUMBO].empty) begin
               rsp.status             = ST_JUMBO_OK;
               rsp.granted_class      = CLASS_JUMBO;
               rsp.granted_index      = stat[CLASS_JUMBO].top;
               cmd[CLASS_JUMBO].pop   = go;
            end else begin
               rsp.status = ST_EXHAUSTED;
            end
         end else if (!stat[CLASS_SMALL].empty) begin
            rsp.status             = ST_SMALL_OK;
            rsp.granted_index      = stat[CLASS_SMALL].top;
            cmd[CLASS_SMALL].pop   = go;
         end else if (!stat[CLASS_JUMBO].empty) begin
            rsp.status             = ST_PROMOTED;
            rsp.granted_class      = CLASS_JUMBO;
            rsp.granted_index      = stat[CLASS_JUMBO].top;
            cmd[CLASS_JUMBO].pop   = go;
         end else begin
            rsp.status = ST_EXHAUSTED;
         end
      end else if (idx_in_range && rel_stat.in_use && !rel_stat.full) begin
         rsp.status                         = ST_RELEASED;
         cmd[item.release_class].push       = go;
         cmd[item.release_class].push_idx   = item.release_index;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for two_class_buffer_pool: stream driver and monitor with
// a cycle-free predictor of both LIFO free lists and the three size registers.
// Depends on tcbp_pkg and the two_class_buffer_pool RTL only.

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tcbp_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int ITEM_BUDGET = 1050;
   localparam int DRAIN_LEN   = 560;
   localparam int INDEX_MAX   = (1 << IDX_W) - 1;
   localparam int PAYLOAD_MAX = (1 << PAYLOAD_W) - 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {PH_DRAIN, PH_CHURN, PH_RETURN} phase_kind;
   typedef enum int {PL_SMALL, PL_JUMBO, PL_OVERSIZE} payload_kind;
   typedef enum int {RDY_OPEN, RDY_RANDOM, RDY_PATTERN} ready_mode;
   typedef enum int {
      CFG_DEFAULT, CFG_TIGHT_SMALL, CFG_ROOMY, CFG_TINY, CFG_RANDOM
   } cfg_mode;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted pool state and register copies
   logic [HEADROOM_W-1:0] headroom;
   logic [SIZE_W-1:0]     small_size;
   logic [SIZE_W-1:0]     jumbo_size;
   logic [IDX_W-1:0]      small_stack [SMALL_BUFFERS];
   logic [IDX_W-1:0]      jumbo_stack [JUMBO_BUFFERS];
   bit                    small_busy  [SMALL_BUFFERS];
   bit                    jumbo_busy  [JUMBO_BUFFERS];
   int                    small_free;
   int                    jumbo_free;

   req_type req_backlog[$];
   rsp_type due_rsp[$];
   req_type held_req;
   int      mismatches  = 0;
   int      idle_cycles = 0;

   two_class_buffer_pool dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // grant or release one buffer, returning the result the block should give
   function automatic rsp_type pool_serve(req_type r);
      rsp_type          a;
      logic [NEED_W-1:0] need;
      a.status        = ST_IGNORED;
      a.granted_class = CLASS_SMALL;
      a.granted_index = '0;
      if (r.cmd == CMD_ALLOC) begin
         need = NEED_W'(r.min_payload_bytes) + NEED_W'(headroom);
         if (need > NEED_W'(jumbo_size)) begin
            a.status = ST_TOO_BIG;
         end else if (need > NEED_W'(small_size) || small_free == 0) begin
            if (jumbo_free == 0) begin
               a.status = ST_EXHAUSTED;
            end else begin
               jumbo_free--;
               a.granted_class = CLASS_JUMBO;
               a.granted_index = jumbo_stack[jumbo_free];
               jumbo_busy[a.granted_index] = 1'b1;
               a.status = (need > NEED_W'(small_size)) ? ST_JUMBO_OK : ST_PROMOTED;
            end
         end else begin
            small_free--;
            a.granted_index = small_stack[small_free];
            small_busy[a.granted_index] = 1'b1;
            a.status = ST_SMALL_OK;
         end
      end else if (r.release_class == CLASS_SMALL) begin
         if (int'(r.release_index) < SMALL_BUFFERS && small_busy[r.release_index]) begin
            small_busy[r.release_index] = 1'b0;
            small_stack[small_free] = r.release_index;
            small_free++;
            a.status = ST_RELEASED;
         end
      end else begin
         if (int'(r.release_index) < JUMBO_BUFFERS && jumbo_busy[r.release_index]) begin
            jumbo_busy[r.release_index] = 1'b0;
            jumbo_stack[jumbo_free] = r.release_index;
            jumbo_free++;
            a.status = ST_RELEASED;
         end
      end
      return a;
   endfunction

   function automatic req_type release_req(class_type c, logic [IDX_W-1:0] idx);
      req_type r;
      r.cmd               = CMD_RELEASE;
      r.min_payload_bytes = PAYLOAD_W'($urandom_range(0, PAYLOAD_MAX));
      r.release_class     = c;
      r.release_index     = idx;
      return r;
   endfunction

   // unused release fields carry random content
   function automatic req_type alloc_req(logic [PAYLOAD_W-1:0] payload);
      req_type r;
      r = release_req(class_type'($urandom_range(0, 1)),
                      IDX_W'($urandom_range(0, INDEX_MAX)));
      r.cmd               = CMD_ALLOC;
      r.min_payload_bytes = payload;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      r = release_req(class_type'($urandom_range(0, 1)),
                      IDX_W'($urandom_range(0, INDEX_MAX)));
      r.cmd = cmd_type'($urandom_range(0, 1));
      return r;
   endfunction

   // payload that lands in the wanted size band under the current registers
   function automatic logic [PAYLOAD_W-1:0] pick_payload(payload_kind k);
      int room_small;
      int room_jumbo;
      room_small = int'(small_size) - int'(headroom);
      room_jumbo = int'(jumbo_size) - int'(headroom);
      case (k)
         PL_SMALL:
            if (room_small >= 0)
               return PAYLOAD_W'($urandom_range(0, room_small));
         PL_JUMBO:
            if (room_jumbo > room_small && room_jumbo >= 0)
               return PAYLOAD_W'($urandom_range((room_small < 0) ? 0 : room_small + 1,
                                                room_jumbo));
         default:
            if (room_jumbo < PAYLOAD_MAX)
               return PAYLOAD_W'($urandom_range((room_jumbo < 0) ? 0 : room_jumbo + 1,
                                                PAYLOAD_MAX));
      endcase
      return PAYLOAD_W'($urandom_range(0, PAYLOAD_MAX));
   endfunction

   task automatic flag_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected status %0d class %0d index %0d, got %0d %0d %0d",
                  $realtime, what, want.status, want.granted_class, want.granted_index,
                  got.status, got.granted_class, got.granted_index);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HEADROOM:   headroom   = val[HEADROOM_W-1:0];
         CSR_SMALL_SIZE: small_size = val;
         CSR_JUMBO_SIZE: jumbo_size = val;
         default: ;
      endcase
   endtask

   task automatic apply_setting(cfg_mode mode);
      logic [CSR_DATA_W-1:0] h;
      logic [CSR_DATA_W-1:0] s;
      logic [CSR_DATA_W-1:0] j;
      case (mode)
         CFG_DEFAULT: begin
            h = CSR_DATA_W'(HEADROOM_RESET); s = SMALL_SIZE_RESET; j = JUMBO_SIZE_RESET;
         end
         CFG_TIGHT_SMALL: begin
            h = '0; s = 16'd1; j = '1;
         end
         CFG_ROOMY: begin
            h = 16'd1535; s = '1; j = '1;
         end
         CFG_TINY: begin
            h = '0; s = 16'd1; j = 16'd1;
         end
         default: begin
            h = CSR_DATA_W'($urandom_range(0, 1535));
            s = CSR_DATA_W'($urandom_range(1, 65535));
            j = CSR_DATA_W'($urandom_range(1, 65535));
         end
      endcase
      csr_write(CSR_HEADROOM, h);
      csr_write(CSR_SMALL_SIZE, s);
      csr_write(CSR_JUMBO_SIZE, j);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || due_rsp.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // request driver: bursts of random length with random gaps between
   int gap_left   = 0;
   int burst_left = 1;
   always @(posedge clock) begin
      req_type nxt;
      if (!reset) begin
         if (req_tvalid && req_tready)
            due_rsp.push_back(pool_serve(held_req));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || req_backlog.size() == 0) begin
               if (gap_left > 0)
                  gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               nxt = req_backlog.pop_front();
               held_req = nxt;
               req_tvalid <= 1'b1;
               req_tdata  <= {6'd0, nxt.release_index, nxt.release_class,
                              nxt.min_payload_bytes};
               req_tuser  <= nxt.cmd;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // result back-pressure: open, random or a repeating 8-bit mask
   ready_mode  rdy_mode    = RDY_OPEN;
   int         rdy_left    = 0;
   int         rdy_step    = 0;
   logic [7:0] rdy_pattern = 8'hFF;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rdy_left == 0) begin
            rdy_mode    = ready_mode'($urandom_range(0, 2));
            rdy_left    = $urandom_range(16, 200);
            rdy_pattern = 8'($urandom_range(1, 255));
         end
         rdy_left--;
         rdy_step++;
         case (rdy_mode)
            RDY_OPEN:   rsp_tready <= 1'b1;
            RDY_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            default:    rsp_tready <= rdy_pattern[rdy_step % 8];
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status        = status_type'(rsp_tuser[2:0]);
         got.granted_class = class_type'(rsp_tdata[0]);
         got.granted_index = rsp_tdata[IDX_W:1];
         if (due_rsp.size() == 0) begin
            flag_mismatch("result beat with none due", '0, got);
         end else begin
            want = due_rsp.pop_front();
            if (got.status !== want.status || got.granted_class !== want.granted_class ||
                got.granted_index !== want.granted_index)
               flag_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("two_class_buffer_pool regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type   frees[$];
      req_type   r;
      phase_kind kind;
      bit        want_free;
      int        n_items;
      int        phase;
      int        len;
      int        k;

      headroom   = HEADROOM_RESET;
      small_size = SMALL_SIZE_RESET;
      jumbo_size = JUMBO_SIZE_RESET;
      for (int i = 0; i < SMALL_BUFFERS; i++) begin
         small_stack[i] = IDX_W'(SMALL_BUFFERS - 1 - i);
         small_busy[i]  = 1'b0;
      end
      for (int i = 0; i < JUMBO_BUFFERS; i++) begin
         jumbo_stack[i] = IDX_W'(JUMBO_BUFFERS - 1 - i);
         jumbo_busy[i]  = 1'b0;
      end
      small_free = SMALL_BUFFERS;
      jumbo_free = JUMBO_BUFFERS;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // spare register index: write must leave the reset sizes alone
      csr_write(CSR_SPARE, '1);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);

      // directed: size boundaries, 17-bit sum, LIFO reuse, double and bad releases
      req_backlog.push_back(alloc_req('0));
      req_backlog.push_back(alloc_req(SMALL_SIZE_RESET - PAYLOAD_W'(HEADROOM_RESET)));
      req_backlog.push_back(alloc_req(SMALL_SIZE_RESET - PAYLOAD_W'(HEADROOM_RESET) + 1'b1));
      req_backlog.push_back(alloc_req('1));
      req_backlog.push_back(alloc_req(JUMBO_SIZE_RESET - PAYLOAD_W'(HEADROOM_RESET)));
      req_backlog.push_back(release_req(CLASS_SMALL, '0));
      req_backlog.push_back(release_req(CLASS_SMALL, '0));
      req_backlog.push_back(release_req(CLASS_JUMBO, IDX_W'(1)));
      req_backlog.push_back(release_req(CLASS_JUMBO, IDX_W'(JUMBO_BUFFERS)));
      req_backlog.push_back(release_req(CLASS_JUMBO, '1));
      req_backlog.push_back(release_req(CLASS_SMALL, '1));
      req_backlog.push_back(alloc_req('0));
      // seven jumbo grants empty the jumbo list, the eighth is refused
      for (int i = 0; i < JUMBO_BUFFERS; i++)
         req_backlog.push_back(alloc_req(16'd2000));
      req_backlog.push_back(release_req(CLASS_JUMBO, IDX_W'(JUMBO_BUFFERS - 1)));
      req_backlog.push_back(release_req(CLASS_SMALL, IDX_W'(1)));
      n_items = req_backlog.size();

      phase = 0;
      while (n_items < ITEM_BUDGET) begin
         wait_idle();
         if (phase < 5)
            apply_setting(cfg_mode'(phase));
         else
            apply_setting(cfg_mode'($urandom_range(0, 4)));
         frees.delete();
         for (int i = 0; i < SMALL_BUFFERS; i++)
            if (small_busy[i])
               frees.push_back(release_req(CLASS_SMALL, IDX_W'(i)));
         for (int i = 0; i < JUMBO_BUFFERS; i++)
            if (jumbo_busy[i])
               frees.push_back(release_req(CLASS_JUMBO, IDX_W'(i)));

         // first drain the small list so later phases see promotion and exhaustion
         if (phase == 0)
            kind = PH_DRAIN;
         else if (phase == 1 || (frees.size() < 300 && $urandom_range(0, 9) < 7))
            kind = PH_CHURN;
         else
            kind = PH_RETURN;
         case (kind)
            PH_DRAIN: len = DRAIN_LEN;
            PH_CHURN: len = $urandom_range(40, 80);
            default:  len = $urandom_range(60, 150);
         endcase

         for (int i = 0; i < len; i++) begin
            k = $urandom_range(0, 99);
            want_free = 1'b0;
            case (kind)
               PH_DRAIN: begin
                  if (k < 95) r = alloc_req(pick_payload(PL_SMALL));
                  else r = random_req();
               end
               PH_CHURN: begin
                  if (k < 30)      r = alloc_req(pick_payload(PL_SMALL));
                  else if (k < 45) r = alloc_req(pick_payload(PL_JUMBO));
                  else if (k < 50) r = alloc_req(pick_payload(PL_OVERSIZE));
                  else if (k < 55) r = random_req();
                  else want_free = 1'b1;
               end
               default: begin
                  if (k < 90)      want_free = 1'b1;
                  else if (k < 95) r = alloc_req(pick_payload(PL_SMALL));
                  else r = random_req();
               end
            endcase
            if (want_free) begin
               if (frees.size() == 0) begin
                  r = random_req();
               end else begin
                  k = $urandom_range(0, frees.size() - 1);
                  r = frees[k];
                  frees.delete(k);
               end
            end
            req_backlog.push_back(r);
         end
         n_items += len;
         phase++;
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0)
         $display("two_class_buffer_pool regression: pass");
      else
         $display("two_class_buffer_pool regression: fail");
      $finish;
   end

endmodule

// ===== two_class_buffer_pool.f =====
rtl/tcbp_pkg.sv
rtl/tcbp_csr.sv
rtl/tcbp_lists.sv
rtl/tcbp_alloc.sv
rtl/two_class_buffer_pool.sv
dv/tb_top.sv
